>>> rtl/aarm_pkg.sv
package aarm_pkg;

	localparam int ATAN_COUNT = 24;
	localparam int TH_W       = 35;
	localparam int XY_W       = 34;
	localparam int AXIS_W     = 16;
	localparam int VAL_W      = 18;
	localparam int SUM_W      = 24;

	localparam logic [1:0] COL_LAST = 2'd3;

	localparam logic signed [TH_W-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [TH_W-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [XY_W-1:0] Q30_GAIN    = 34'sd652032874;
	localparam logic signed [VAL_W-1:0] ONE_Q14    = 18'sd16384;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
	} axis_t;

	function automatic logic signed [TH_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [TH_W-1:0] r;
		unique case (i)
			5'd0:  r = 35'sd843314856;
			5'd1:  r = 35'sd497837829;
			5'd2:  r = 35'sd263043836;
			5'd3:  r = 35'sd133525158;
			5'd4:  r = 35'sd67021686;
			5'd5:  r = 35'sd33543515;
			5'd6:  r = 35'sd16775850;
			5'd7:  r = 35'sd8388437;
			5'd8:  r = 35'sd4194282;
			5'd9:  r = 35'sd2097149;
			5'd10: r = 35'sd1048575;
			5'd11: r = 35'sd524287;
			5'd12: r = 35'sd262143;
			5'd13: r = 35'sd131071;
			5'd14: r = 35'sd65535;
			5'd15: r = 35'sd32767;
			5'd16: r = 35'sd16383;
			5'd17: r = 35'sd8191;
			5'd18: r = 35'sd4095;
			5'd19: r = 35'sd2047;
			5'd20: r = 35'sd1023;
			5'd21: r = 35'sd511;
			5'd22: r = 35'sd255;
			5'd23: r = 35'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic val_t sat18(input logic signed [SUM_W-1:0] v);
		val_t r;
		if (v > 24'sd131071)
			r = 18'sd131071;
		else if (v < -24'sd131072)
			r = -18'sd131072;
		else
			r = v[VAL_W-1:0];
		return r;
	endfunction

endpackage

>>> rtl/axis_angle_rotation_matrix_unit.sv
// Path from an accepted request to column 0: the fold stage, the CORDIC steps, stages 2 to 4
// and the output register; the CORDIC runs at most 24 steps.
// The single result port sends one column a cycle while res_ready is high.
// The pipeline accepts a request each cycle while the output register is free.
// Reset (arst_n low, asynchronous) clears all valid bits and the column counter.
module axis_angle_rotation_matrix_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic signed [15:0]                  angle,
	input  logic signed [15:0]                  axis_x,
	input  logic signed [15:0]                  axis_y,
	input  logic signed [15:0]                  axis_z,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [1:0]                          column,
	output logic signed [17:0]                  row0_value,
	output logic signed [17:0]                  row1_value,
	output logic signed [17:0]                  row2_value,
	output logic signed [17:0]                  row3_value,
	output logic                                last
);
	import aarm_pkg::*;

	logic en;
	logic [1:0] col_q;
	logic ov_q;

	// advance the whole pipe when the output register is empty or drains its last column
	assign en        = !ov_q || (res_ready && col_q == COL_LAST);
	assign req_ready = en;

	// stage 1: scale to Q2.30 and fold into +-pi/2
	logic signed [TH_W-1:0] th_in, th_s1;
	logic flip_s1, v_s1;
	axis_t axis_s1;

	assign th_in = TH_W'(angle) <<< 17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s1 <= '{x: axis_x, y: axis_y, z: axis_z};
			if (th_in > Q30_HALF_PI) begin
				th_s1 <= th_in - Q30_PI; flip_s1 <= 1'b1;
			end else if (th_in < -Q30_HALF_PI) begin
				th_s1 <= th_in + Q30_PI; flip_s1 <= 1'b1;
			end else begin
				th_s1 <= th_in; flip_s1 <= 1'b0;
			end
		end
	end

	logic cv;
	logic signed [XY_W-1:0] cx, cy;
	logic cflip;
	axis_t caxis;

	aarm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_th    (th_s1),
		.in_flip  (flip_s1),
		.in_axis  (axis_s1),
		.out_valid(cv),
		.out_x    (cx),
		.out_y    (cy),
		.out_flip (cflip),
		.out_axis (caxis)
	);

	// stage 2: undo fold, round to Q1.14, form d
	logic signed [XY_W-1:0] xf, yf, xr, yr;
	val_t c_s2, s_s2, d_s2, c_n;
	axis_t axis_s2;
	logic v_s2;

	always_comb begin
		xf  = cflip ? -cx : cx;
		yf  = cflip ? -cy : cy;
		xr  = (xf + XY_W'(32768)) >>> 16;
		yr  = (yf + XY_W'(32768)) >>> 16;
		c_n = xr[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= cv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= c_n;
			s_s2    <= yr[VAL_W-1:0];
			d_s2    <= ONE_Q14 - c_n;
			axis_s2 <= caxis;
		end
	end

	// stage 3: axis products and sine terms
	logic signed [31:0] ab_s3 [0:5];
	val_t ts_s3 [0:2];
	val_t c_s3, d_s3;
	logic v_s3;
	logic signed [33:0] ps_x, ps_y, ps_z, rs_x, rs_y, rs_z;

	always_comb begin
		ps_x = axis_s2.x * s_s2;
		ps_y = axis_s2.y * s_s2;
		ps_z = axis_s2.z * s_s2;
		rs_x = (ps_x + 34'sd8192) >>> 14;
		rs_y = (ps_y + 34'sd8192) >>> 14;
		rs_z = (ps_z + 34'sd8192) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_s3[0] <= axis_s2.x * axis_s2.x;
			ab_s3[1] <= axis_s2.x * axis_s2.y;
			ab_s3[2] <= axis_s2.x * axis_s2.z;
			ab_s3[3] <= axis_s2.y * axis_s2.y;
			ab_s3[4] <= axis_s2.y * axis_s2.z;
			ab_s3[5] <= axis_s2.z * axis_s2.z;
			ts_s3[0] <= rs_x[VAL_W-1:0];
			ts_s3[1] <= rs_y[VAL_W-1:0];
			ts_s3[2] <= rs_z[VAL_W-1:0];
			c_s3     <= c_s2;
			d_s3     <= d_s2;
		end
	end

	// stage 4: scale by d and round to Q.14
	logic signed [21:0] td_s4 [0:5];
	val_t ts_s4 [0:2];
	val_t c_s4;
	logic v_s4;
	logic signed [49:0] pd [0:5];
	logic signed [49:0] rd [0:5];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			pd[i] = ab_s3[i] * d_s3;
			rd[i] = (pd[i] + 50'sd134217728) >>> 28;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++)
				td_s4[i] <= rd[i][21:0];
			for (int i = 0; i < 3; i++)
				ts_s4[i] <= ts_s3[i];
			c_s4 <= c_s3;
		end
	end

	// output register: nine matrix elements, column-major
	logic signed [SUM_W-1:0] txx, txy, txz, tyy, tyz, tzz, sx, sy, sz, cc;
	val_t m_n [0:8];
	val_t m_q [0:8];

	always_comb begin
		txx = SUM_W'(td_s4[0]);
		txy = SUM_W'(td_s4[1]);
		txz = SUM_W'(td_s4[2]);
		tyy = SUM_W'(td_s4[3]);
		tyz = SUM_W'(td_s4[4]);
		tzz = SUM_W'(td_s4[5]);
		sx  = SUM_W'(ts_s4[0]);
		sy  = SUM_W'(ts_s4[1]);
		sz  = SUM_W'(ts_s4[2]);
		cc  = SUM_W'(c_s4);
		m_n[0] = sat18(txx + cc);
		m_n[1] = sat18(txy + sz);
		m_n[2] = sat18(txz - sy);
		m_n[3] = sat18(txy - sz);
		m_n[4] = sat18(tyy + cc);
		m_n[5] = sat18(tyz + sx);
		m_n[6] = sat18(txz + sy);
		m_n[7] = sat18(tyz - sx);
		m_n[8] = sat18(tzz + cc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			col_q <= '0;
		end else if (en) begin
			ov_q  <= v_s4;
			col_q <= '0;
		end else if (res_ready) begin
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			for (int i = 0; i < 9; i++)
				m_q[i] <= m_n[i];
	end

	always_comb begin
		unique case (col_q)
			2'd0: begin
				row0_value = m_q[0]; row1_value = m_q[1]; row2_value = m_q[2];
			end
			2'd1: begin
				row0_value = m_q[3]; row1_value = m_q[4]; row2_value = m_q[5];
			end
			2'd2: begin
				row0_value = m_q[6]; row1_value = m_q[7]; row2_value = m_q[8];
			end
			default: begin
				row0_value = '0; row1_value = '0; row2_value = '0;
			end
		endcase
	end

	assign res_valid  = ov_q;
	assign column     = col_q;
	assign last       = (col_q == COL_LAST);
	assign row3_value = last ? ONE_Q14 : '0;

endmodule

>>> rtl/aarm_cordic.sv
module aarm_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [aarm_pkg::TH_W-1:0]      in_th,
	input  logic                                  in_flip,
	input  aarm_pkg::axis_t                       in_axis,
	output logic                                  out_valid,
	output logic signed [aarm_pkg::XY_W-1:0]      out_x,
	output logic signed [aarm_pkg::XY_W-1:0]      out_y,
	output logic                                  out_flip,
	output aarm_pkg::axis_t                       out_axis
);
	import aarm_pkg::*;

	localparam int N = (STEPS < ATAN_COUNT) ? STEPS : ATAN_COUNT;

	logic signed [XY_W-1:0] x_s  [0:N];
	logic signed [XY_W-1:0] y_s  [0:N];
	logic signed [TH_W-1:0] th_s [0:N];
	logic                   flip_s [0:N];
	axis_t                  axis_s [0:N];
	logic                   v_s  [0:N];

	assign x_s[0]    = Q30_GAIN;
	assign y_s[0]    = '0;
	assign th_s[0]   = in_th;
	assign flip_s[0] = in_flip;
	assign axis_s[0] = in_axis;
	assign v_s[0]    = in_valid;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic signed [XY_W-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				// rotate toward zero residual angle
				if (!th_s[k][TH_W-1]) begin
					x_s[k+1]  <= x_s[k] - ys;
					y_s[k+1]  <= y_s[k] + xs;
					th_s[k+1] <= th_s[k] - atan_q30(5'(k));
				end else begin
					x_s[k+1]  <= x_s[k] + ys;
					y_s[k+1]  <= y_s[k] - xs;
					th_s[k+1] <= th_s[k] + atan_q30(5'(k));
				end
				flip_s[k+1] <= flip_s[k];
				axis_s[k+1] <= axis_s[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_x     = x_s[N];
	assign out_y     = y_s[N];
	assign out_flip  = flip_s[N];
	assign out_axis  = axis_s[N];

endmodule

>>> rtl/aarm_checker.sv
module aarm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic signed [15:0] angle,
	input logic signed [15:0] axis_x,
	input logic signed [15:0] axis_y,
	input logic signed [15:0] axis_z,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         column,
	input logic signed [17:0] row0_value,
	input logic signed [17:0] row1_value,
	input logic signed [17:0] row2_value,
	input logic signed [17:0] row3_value,
	input logic               last
);
	import aarm_pkg::*;

	a_col_advance: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last |=> res_valid && column == $past(column) + 2'd1)
		else $error("column did not advance within a matrix");

	a_col_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && last |=> !res_valid || column == 2'd0)
		else $error("new matrix did not start at column 0");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> last == (column == COL_LAST))
		else $error("last flag does not match column");

	a_row3: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> row3_value == (last ? ONE_Q14 : 18'sd0))
		else $error("bottom row element wrong");

endmodule

bind axis_angle_rotation_matrix_unit aarm_checker u_aarm_checker (.*);

>>> tb/rotation_matrix_checker.sv
module rotation_matrix_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic [1:0]         column,
	input  logic signed [17:0] row0_value,
	input  logic signed [17:0] row1_value,
	input  logic signed [17:0] row2_value,
	input  logic signed [17:0] row3_value,
	input  logic               last,
	output int                 fail_count,
	output int                 pending_columns
);
	import aarm_pkg::*;

	localparam int STEPS = 16;

	typedef struct packed {
		logic [1:0] col;
		val_t       r0;
		val_t       r1;
		val_t       r2;
		val_t       r3;
		logic       lst;
	} column_t;

	column_t column_q[$];

	function automatic longint floor_shr(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic longint atan_entry(input int i);
		longint tab [24] = '{843314856, 497837829, 263043836, 133525158,
			67021686, 33543515, 16775850, 8388437, 4194282, 2097149,
			1048575, 524287, 262143, 131071, 65535, 32767, 16383, 8191,
			4095, 2047, 1023, 511, 255, 127};
		return tab[i];
	endfunction

	function automatic val_t clamp18(input longint v);
		if (v > 131071)
			return 18'sd131071;
		if (v < -131072)
			return -18'sd131072;
		return val_t'(v);
	endfunction

	function automatic longint prod_d(input longint a, input longint b, input longint d);
		return floor_shr(a * b * d + (64'sd1 <<< 27), 28);
	endfunction

	function automatic longint prod_s(input longint a, input longint s);
		return floor_shr(a * s + (64'sd1 <<< 13), 14);
	endfunction

	task automatic predict_matrix(input longint ang, input longint ax, input longint ay,
			input longint az);
		longint th, x, y, nx, c, s, d;
		longint m [4][4];
		bit flip;
		column_t e;
		th = ang * 131072;
		x = 652032874;
		y = 0;
		flip = 0;
		if (th > 1686629713) begin
			th -= 64'sd3373259426;
			flip = 1;
		end else if (th < -1686629713) begin
			th += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			if (th >= 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				th -= atan_entry(i);
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				th += atan_entry(i);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = floor_shr(x + 32768, 16);
		s = floor_shr(y + 32768, 16);
		d = 16384 - c;
		m[0][0] = prod_d(ax, ax, d) + c;
		m[0][1] = prod_d(ax, ay, d) + prod_s(az, s);
		m[0][2] = prod_d(ax, az, d) - prod_s(ay, s);
		m[1][0] = prod_d(ax, ay, d) - prod_s(az, s);
		m[1][1] = prod_d(ay, ay, d) + c;
		m[1][2] = prod_d(ay, az, d) + prod_s(ax, s);
		m[2][0] = prod_d(ax, az, d) + prod_s(ay, s);
		m[2][1] = prod_d(ay, az, d) - prod_s(ax, s);
		m[2][2] = prod_d(az, az, d) + c;
		for (int k = 0; k < 3; k++)
			m[k][3] = 0;
		m[3][0] = 0;
		m[3][1] = 0;
		m[3][2] = 0;
		m[3][3] = 16384;
		for (int k = 0; k < 4; k++) begin
			e.col = 2'(k);
			e.r0 = clamp18(m[k][0]);
			e.r1 = clamp18(m[k][1]);
			e.r2 = clamp18(m[k][2]);
			e.r3 = clamp18(m[k][3]);
			e.lst = (2'(k) == COL_LAST);
			column_q.push_back(e);
		end
	endtask

	initial begin
		fail_count = 0;
	end

	assign pending_columns = column_q.size();

	always @(posedge clk) begin
		column_t e, got;
		if (arst_n) begin
			if (req_valid && req_ready)
				predict_matrix(angle, axis_x, axis_y, axis_z);
			if (res_valid && res_ready) begin
				got = '{column, row0_value, row1_value, row2_value, row3_value, last};
				if (column_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected column %0d", column);
				end else begin
					e = column_q.pop_front();
					if (got !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp col %0d %0d %0d %0d %0d last %0b,",
								" got col %0d %0d %0d %0d %0d last %0b"},
								e.col, e.r0, e.r1, e.r2, e.r3, e.lst,
								got.col, got.r0, got.r1, got.r2, got.r3, got.lst);
					end
				end
			end
		end
	end
endmodule

>>> tb/tb_axis_angle_rotation_matrix_unit.sv
module tb_axis_angle_rotation_matrix_unit;
	logic               clk = 0;
	logic               arst_n = 0;
	logic               req_valid = 0;
	logic               req_ready;
	logic signed [15:0] angle = '0;
	logic signed [15:0] axis_x = '0;
	logic signed [15:0] axis_y = '0;
	logic signed [15:0] axis_z = '0;
	logic               res_valid;
	logic               res_ready = 0;
	logic [1:0]         column;
	logic signed [17:0] row0_value, row1_value, row2_value, row3_value;
	logic               last;
	int                 fail_count;
	int                 pending_columns;
	bit                 calm = 0;
	bit                 hold_off = 0;

	always #2 clk = ~clk;

	axis_angle_rotation_matrix_unit dut (.*);

	rotation_matrix_checker checker_i (.*);

	task automatic send_request(input logic signed [15:0] a, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] z);
		if (!calm && $urandom_range(3) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		req_valid <= 1;
		angle <= a;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_axis();
		case ($urandom_range(5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// random stall bursts on the result side, a long hold while hold_off is set
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_ready <= 0;
				repeat (200) @(negedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(3) == 0) begin
				res_ready <= 0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				res_ready <= 1;
			end else
				res_ready <= 1;
		end
	end

	initial begin
		logic signed [15:0] a;
		logic signed [15:0] special [8] = '{16'sd25736, -16'sd25736, 16'sd0, 16'sd32767,
			-16'sd32768, 16'sd12868, -16'sd12868, 16'sd12869};
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		foreach (special[i])
			send_request(special[i], 16'sd9459, -16'sd9459, 16'sd9459);
		send_request(16'sd8000, 16'sd16384, 16'sd0, 16'sd0);
		send_request(16'sd8000, 16'sd0, 16'sd16384, 16'sd0);
		send_request(16'sd8000, 16'sd0, 16'sd0, 16'sd16384);
		send_request(16'sd25736, 16'sd32767, 16'sd32767, 16'sd32767);
		send_request(-16'sd25736, -16'sd32768, -16'sd32768, -16'sd32768);
		send_request(16'sd20000, -16'sd32768, 16'sd32767, -16'sd1);
		send_request(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
		// stall the result side while requests keep coming
		hold_off = 1;
		repeat (30)
			send_request(16'($urandom), pick_axis(), pick_axis(), pick_axis());
		// let the pipeline drain before the next burst
		req_valid <= 0;
		while (pending_columns != 0)
			@(negedge clk);
		for (int n = 0; n < 460; n++) begin
			if (n == 400)
				calm = 1;
			a = ($urandom_range(7) == 0) ? 16'($urandom)
				: 16'($signed($urandom_range(51472)) - 25736);
			send_request(a, pick_axis(), pick_axis(), pick_axis());
		end
		req_valid <= 0;
		while (pending_columns != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending_columns == 0)
			$display("PASS axis_angle_rotation_matrix_unit");
		else
			$display("FAIL axis_angle_rotation_matrix_unit");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL axis_angle_rotation_matrix_unit");
		$finish;
	end
endmodule
